// ===== src/dcr_pkg.sv =====
// Shared types, constants and arithmetic helpers of the disk collision relaxer.
`default_nettype none
package dcr_pkg;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_STEP   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PALETTE = 2'd0;
  localparam logic [1:0] CFG_AIR     = 2'd1;
  localparam logic [1:0] CFG_NUDGE   = 2'd2;
  localparam logic [1:0] CFG_MOVE    = 2'd3;

  // Field widths.
  localparam int POS_W = 19;
  localparam int VEL_W = 16;
  localparam int RAD_W = 6;
  localparam int CNT_W = 12;
  localparam int IDX_W = 6;
  localparam int REC_W = 2 * POS_W + RAD_W + 2 * VEL_W;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic rd_en;
    logic load_i;
    logic damp_mul;
    logic damp_fin;
    logic pair_mul;
    logic pair_upd;
    logic write_i;
    logic append;
    logic out_load;
    logic out_empty;
    logic out_last;
    logic clr_total;
  } dcr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dcr_stat_t;

  // Saturate an 18-bit signed value to the velocity range.
  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VEL_W+1:0] v);
    logic signed [VEL_W+1:0] vmax;
    logic signed [VEL_W+1:0] vmin;
    vmax = 18'sd32767;
    vmin = -18'sd32768;
    if (v > vmax) sat_vel = 16'sh7fff;
    else if (v < vmin) sat_vel = 16'sh8000;
    else sat_vel = v[VEL_W-1:0];
  endfunction

  // Saturate a 20-bit signed value to the position range.
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
    if (v[POS_W] != v[POS_W-1]) sat_pos = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                                     : {1'b0, {(POS_W-1){1'b1}}};
    else sat_pos = v[POS_W-1:0];
  endfunction

  // Upper wall (palette - r) * 256 as a 20-bit signed value.
  function automatic logic signed [POS_W:0] wall_hi(input logic [9:0] pal,
                                                    input logic [RAD_W-1:0] r);
    logic signed [11:0] d;
    d = $signed({2'b00, pal}) - $signed({6'b0, r});
    wall_hi = {d, 8'b0};
  endfunction

  // Lower wall r * 256 as a 20-bit signed value.
  function automatic logic signed [POS_W:0] wall_lo(input logic [RAD_W-1:0] r);
    wall_lo = $signed({6'b0, r, 8'b0});
  endfunction

  // Velocity plus a signed offset, saturated.
  function automatic logic signed [VEL_W-1:0] add_vel(input logic signed [VEL_W-1:0] v,
                                                      input logic [7:0] n,
                                                      input logic neg);
    logic signed [VEL_W+1:0] e;
    logic signed [VEL_W+1:0] d;
    e = {{2{v[VEL_W-1]}}, v};
    d = $signed({10'b0, n});
    add_vel = neg ? sat_vel(e - d) : sat_vel(e + d);
  endfunction

endpackage
`default_nettype wire

// ===== src/dcr_if.sv =====
// Channel interfaces of the disk collision relaxer.
`default_nettype none
interface dcr_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic signed [18:0]  pos_x;
  logic signed [18:0]  pos_y;
  logic [5:0]          radius;
  modport source (output valid, op, pos_x, pos_y, radius, input ready);
  modport sink (input valid, op, pos_x, pos_y, radius, output ready);
endinterface

interface dcr_out_if;
  logic                valid;
  logic                ready;
  logic [5:0]          disk_index;
  logic signed [18:0]  new_x;
  logic signed [18:0]  new_y;
  logic [11:0]         overlap_count;
  logic                last;
  modport source (output valid, disk_index, new_x, new_y, overlap_count, last, input ready);
  modport sink (input valid, disk_index, new_x, new_y, overlap_count, last, output ready);
endinterface

interface dcr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [9:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/dcr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/dcr_ctrl.sv =====
// Controller state machine of the disk collision relaxer.
`default_nettype none
module dcr_ctrl #(
  parameter int MAX_DISKS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic [1:0]                   in_op,
  output logic                              in_ready,
  input  wire dcr_pkg::dcr_stat_t           stat,
  output dcr_pkg::dcr_cmd_t                 cmd,
  output logic [$clog2(MAX_DISKS)-1:0]      raddr,
  output logic [$clog2(MAX_DISKS)-1:0]      waddr,
  output logic [$clog2(MAX_DISKS)-1:0]      out_idx
);
  import dcr_pkg::*;

  localparam int IW = $clog2(MAX_DISKS);
  localparam int CW = $clog2(MAX_DISKS + 2);
  localparam logic [CW-1:0] MAXC = CW'(MAX_DISKS);

  typedef enum logic [3:0] {
    S_IDLE, S_EMPTY, S_I_RD, S_I_LD, S_D_MUL, S_D_FIN,
    S_J_RD, S_J_MUL, S_J_UPD, S_I_WR, S_O_RD, S_O_LD
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] j_first, j_next, i_inc, j_inc;
  logic          accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign i_inc    = i_r + CW'(1);
  assign j_inc    = j_r + CW'(1);

  // Partner index order skips the disk under test.
  assign j_first = (i_r == '0) ? CW'(1) : '0;
  assign j_next  = (j_inc == i_r) ? j_r + CW'(2) : j_inc;

  // Next state, counters and commands.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cmd       = '0;
    raddr     = i_r[IW-1:0];
    waddr     = i_r[IW-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_CLEAR: count_nxt = '0;
            OP_APPEND: begin
              if (count_r < MAXC) begin
                cmd.append = 1'b1;
                waddr      = count_r[IW-1:0];
                count_nxt  = count_r + CW'(1);
              end
            end
            OP_STEP: begin
              cmd.clr_total = 1'b1;
              i_nxt         = '0;
              state_nxt     = (count_r == '0) ? S_EMPTY : S_I_RD;
            end
            default: ;
          endcase
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.out_empty = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_I_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_I_LD;
      end
      S_I_LD: begin
        cmd.load_i = 1'b1;
        state_nxt  = S_D_MUL;
      end
      S_D_MUL: begin
        cmd.damp_mul = 1'b1;
        state_nxt    = S_D_FIN;
      end
      S_D_FIN: begin
        cmd.damp_fin = 1'b1;
        j_nxt        = j_first;
        state_nxt    = (j_first >= count_r) ? S_I_WR : S_J_RD;
      end
      S_J_RD: begin
        cmd.rd_en = 1'b1;
        raddr     = j_r[IW-1:0];
        state_nxt = S_J_MUL;
      end
      S_J_MUL: begin
        cmd.pair_mul = 1'b1;
        state_nxt    = S_J_UPD;
      end
      S_J_UPD: begin
        cmd.pair_upd = 1'b1;
        waddr        = j_r[IW-1:0];
        j_nxt        = j_next;
        state_nxt    = (j_next >= count_r) ? S_I_WR : S_J_RD;
      end
      S_I_WR: begin
        cmd.write_i = 1'b1;
        i_nxt       = (i_inc == count_r) ? '0 : i_inc;
        state_nxt   = (i_inc == count_r) ? S_O_RD : S_I_RD;
      end
      S_O_RD: begin
        if (stat.out_free) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_O_LD;
        end
      end
      S_O_LD: begin
        cmd.out_load = 1'b1;
        cmd.out_last = (i_inc == count_r);
        i_nxt        = i_inc;
        state_nxt    = (i_inc == count_r) ? S_IDLE : S_O_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_idx = i_r[IW-1:0];

  // State and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== src/dcr_dp.sv =====
// Datapath of the disk collision relaxer: disk store, arithmetic and output register.
`default_nettype none
module dcr_dp #(
  parameter int MAX_DISKS = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire dcr_pkg::dcr_cmd_t        cmd,
  output dcr_pkg::dcr_stat_t            stat,
  input  wire logic [$clog2(MAX_DISKS)-1:0] raddr,
  input  wire logic [$clog2(MAX_DISKS)-1:0] waddr,
  input  wire logic [$clog2(MAX_DISKS)-1:0] out_idx,
  input  wire logic signed [18:0]       app_x,
  input  wire logic signed [18:0]       app_y,
  input  wire logic [5:0]               app_r,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [9:0]               cfg_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [5:0]                    out_disk_index,
  output logic signed [18:0]            out_new_x,
  output logic signed [18:0]            out_new_y,
  output logic [11:0]                   out_overlap_count,
  output logic                          out_last
);
  import dcr_pkg::*;

  localparam int IW = $clog2(MAX_DISKS);

  // Configuration registers.
  logic [9:0] pal_r;
  logic [8:0] air_r;
  logic [7:0] nudge_r;
  logic       move_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_r   <= 10'd775;
      air_r   <= 9'd243;
      nudge_r <= 8'd13;
      move_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PALETTE: pal_r   <= cfg_data;
        CFG_AIR:     air_r   <= cfg_data[8:0];
        CFG_NUDGE:   nudge_r <= cfg_data[7:0];
        CFG_MOVE:    move_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Disk store.
  logic             we;
  logic [REC_W-1:0] wdata, rdata;

  dcr_ram #(.WIDTH(REC_W), .DEPTH(MAX_DISKS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic signed [POS_W-1:0] rd_x, rd_y;
  logic [RAD_W-1:0]        rd_r;
  logic signed [VEL_W-1:0] rd_vx, rd_vy;
  assign {rd_x, rd_y, rd_r, rd_vx, rd_vy} = rdata;

  // Working registers of disk i and partner j.
  logic signed [POS_W-1:0] xi_r, yi_r, xj_r, yj_r;
  logic [RAD_W-1:0]        ri_r, rj_r;
  logic signed [VEL_W-1:0] vxi_r, vyi_r, vxj_r, vyj_r;
  logic                    hits_r;
  logic signed [25:0]      pxm_r, pym_r;
  logic [39:0]             dx2_r, dy2_r;
  logic [13:0]             rsq_r;
  logic [CNT_W-1:0]        total_r;

  // Damping, wall reflection, pair distance and nudges.
  logic signed [VEL_W-1:0] dvx, dvy, wvx, wvy, nvxi, nvyi, nvxj, nvyj;
  logic signed [POS_W:0]   hi_i, lo_i, xi_e, yi_e;
  logic signed [POS_W:0]   dx, dy;
  logic signed [39:0]      dxs, dys;
  logic [6:0]              rsum;
  logic [40:0]             dsum;
  logic                    ovl, ltx, lty;
  logic signed [POS_W-1:0] fx, fy, mx, my;

  assign dvx  = sat_vel(pxm_r[25:8]);
  assign dvy  = sat_vel(pym_r[25:8]);
  assign hi_i = wall_hi(pal_r, ri_r);
  assign lo_i = wall_lo(ri_r);
  assign xi_e = {xi_r[POS_W-1], xi_r};
  assign yi_e = {yi_r[POS_W-1], yi_r};
  assign wvx  = (xi_e > hi_i || xi_e < lo_i) ? sat_vel(-{{2{dvx[VEL_W-1]}}, dvx}) : dvx;
  assign wvy  = (yi_e > hi_i || yi_e < lo_i) ? sat_vel(-{{2{dvy[VEL_W-1]}}, dvy}) : dvy;

  assign dx   = xi_e - {rd_x[POS_W-1], rd_x};
  assign dy   = yi_e - {rd_y[POS_W-1], rd_y};
  assign dxs  = dx * dx;
  assign dys  = dy * dy;
  assign rsum = {1'b0, ri_r} + {1'b0, rd_r};

  assign dsum = {1'b0, dx2_r} + {1'b0, dy2_r};
  assign ovl  = dsum < {11'b0, rsq_r, 16'b0};
  assign ltx  = xi_r < xj_r;
  assign lty  = yi_r < yj_r;
  assign nvxi = add_vel(vxi_r, nudge_r, ltx);
  assign nvyi = add_vel(vyi_r, nudge_r, lty);
  assign nvxj = add_vel(vxj_r, nudge_r, !ltx);
  assign nvyj = add_vel(vyj_r, nudge_r, !lty);

  // Fence the position of i inside the walls.
  always_comb begin
    logic signed [POS_W:0] qx, qy;
    qx = xi_e;
    qy = yi_e;
    if (qx > hi_i) qx = hi_i;
    if (qx < lo_i) qx = lo_i;
    if (qy > hi_i) qy = hi_i;
    if (qy < lo_i) qy = lo_i;
    fx = sat_pos(qx);
    fy = sat_pos(qy);
  end

  assign mx = sat_pos(xi_e + {{(POS_W-VEL_W+1){vxi_r[VEL_W-1]}}, vxi_r});
  assign my = sat_pos(yi_e + {{(POS_W-VEL_W+1){vyi_r[VEL_W-1]}}, vyi_r});

  // Store write selection.
  always_comb begin
    we    = 1'b0;
    wdata = {xi_r, yi_r, ri_r, vxi_r, vyi_r};
    if (cmd.append) begin
      we    = 1'b1;
      wdata = {app_x, app_y, app_r, {VEL_W{1'b0}}, {VEL_W{1'b0}}};
    end else if (cmd.pair_upd) begin
      we    = ovl;
      wdata = {xj_r, yj_r, rj_r, nvxj, nvyj};
    end else if (cmd.write_i) begin
      we = 1'b1;
      if (!move_r || hits_r) wdata = {mx, my, ri_r, vxi_r, vyi_r};
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load_i) begin
      xi_r   <= rd_x;
      yi_r   <= rd_y;
      ri_r   <= rd_r;
      vxi_r  <= rd_vx;
      vyi_r  <= rd_vy;
      hits_r <= 1'b0;
    end
    if (cmd.damp_mul) begin
      pxm_r <= vxi_r * $signed({1'b0, air_r});
      pym_r <= vyi_r * $signed({1'b0, air_r});
    end
    if (cmd.damp_fin) begin
      vxi_r <= wvx;
      vyi_r <= wvy;
    end
    if (cmd.pair_mul) begin
      xj_r  <= rd_x;
      yj_r  <= rd_y;
      rj_r  <= rd_r;
      vxj_r <= rd_vx;
      vyj_r <= rd_vy;
      dx2_r <= dxs[39:0];
      dy2_r <= dys[39:0];
      rsq_r <= rsum * rsum;
    end
    if (cmd.pair_upd && ovl) begin
      hits_r <= 1'b1;
      vxi_r  <= nvxi;
      vyi_r  <= nvyi;
      xi_r   <= fx;
      yi_r   <= fy;
    end
  end

  // Overlap total of the pass, saturating.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_total) total_r <= '0;
    else if (cmd.pair_upd && ovl && total_r != CNT_MAX) total_r <= total_r + CNT_W'(1);
  end

  // Output register.
  logic out_valid_r;
  assign out_valid     = out_valid_r;
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load || cmd.out_empty) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_empty) begin
      out_disk_index    <= '0;
      out_new_x         <= '0;
      out_new_y         <= '0;
      out_overlap_count <= '0;
      out_last          <= 1'b1;
    end else if (cmd.out_load) begin
      out_disk_index    <= IDX_W'(out_idx);
      out_new_x         <= rd_x;
      out_new_y         <= rd_y;
      out_overlap_count <= cmd.out_last ? total_r : '0;
      out_last          <= cmd.out_last;
    end
  end
endmodule
`default_nettype wire

// ===== src/disk_collision_relax_step.sv =====
// Top level of the disk collision relaxer: channels, controller and datapath.
// An append or clear is taken while idle. A step relaxes the n stored disks pairwise,
// then loads n results, each once the output register is free; new input waits meanwhile.
// Each partner test runs in order: store read, registered squares, compare and update.
// Reset restores the configuration defaults and empties the store; the store itself
// is not cleared and entries at or above the disk count are never read.
`default_nettype none
module disk_collision_relax_step #(
  parameter int MAX_DISKS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dcr_in_if.sink    in_chan,
  dcr_out_if.source out_chan,
  dcr_cfg_if.sink   cfg_chan
);
  import dcr_pkg::*;

  localparam int IW = $clog2(MAX_DISKS);

  dcr_cmd_t      cmd;
  dcr_stat_t     stat;
  logic [IW-1:0] raddr, waddr, out_idx;

  assign cfg_chan.ready = 1'b1;

  dcr_ctrl #(.MAX_DISKS(MAX_DISKS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_op    (in_chan.op),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd),
    .raddr    (raddr),
    .waddr    (waddr),
    .out_idx  (out_idx)
  );

  dcr_dp #(.MAX_DISKS(MAX_DISKS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .raddr             (raddr),
    .waddr             (waddr),
    .out_idx           (out_idx),
    .app_x             (in_chan.pos_x),
    .app_y             (in_chan.pos_y),
    .app_r             (in_chan.radius),
    .cfg_we            (cfg_chan.valid),
    .cfg_index         (cfg_chan.index),
    .cfg_data          (cfg_chan.data),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_disk_index    (out_chan.disk_index),
    .out_new_x         (out_chan.new_x),
    .out_new_y         (out_chan.new_y),
    .out_overlap_count (out_chan.overlap_count),
    .out_last          (out_chan.last)
  );

  // A step keeps the input side busy in the following cycle.
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && in_chan.op == OP_STEP |=> !in_chan.ready)
    else $error("input accepted right after a step transaction");

  // The overlap total appears only on the final result of a step.
  a_count_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.last |-> out_chan.overlap_count == '0)
    else $error("overlap count on a result that is not last");

  // The controller never loads the output register while it still holds a result.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load || cmd.out_empty) |-> stat.out_free)
    else $error("output register overwritten");
endmodule
`default_nettype wire
